// ===== rtl/sic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_pkg
// Types and constants shared by the segment intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;

	localparam int QBITS = 41;

	localparam logic [2:0] REL_CROSS_ON  = 3'd0;
	localparam logic [2:0] REL_CROSS_OFF = 3'd1;
	localparam logic [2:0] REL_PARALLEL  = 3'd2;
	localparam logic [2:0] REL_OVERLAP   = 3'd3;
	localparam logic [2:0] REL_APART     = 3'd4;

	localparam logic        REG_TOL   = 1'b0;
	localparam logic [47:0] TOL_RESET = 48'd1;

	typedef struct packed {
		logic signed [23:0] a_start_x;
		logic signed [23:0] a_start_y;
		logic signed [23:0] a_end_x;
		logic signed [23:0] a_end_y;
		logic signed [23:0] b_start_x;
		logic signed [23:0] b_start_y;
		logic signed [23:0] b_end_x;
		logic signed [23:0] b_end_y;
	} seg_t;

	typedef struct packed {
		logic        [2:0]  relation;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
	} res_t;

	// point = base + d * num / den, rounded, per coordinate
	typedef struct packed {
		logic        [2:0]  rel;
		logic signed [23:0] base_x;
		logic signed [23:0] base_y;
		logic signed [25:0] dx;
		logic signed [25:0] dy;
		logic signed [50:0] num;
		logic        [49:0] den;
	} mid_t;

	localparam int MID_W = $bits(mid_t);
	localparam int RES_W = $bits(res_t);

endpackage

// ===== rtl/sic_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_fifo
// Small synchronous queue built from flops, first word on rdata.
// ----------------------------------------------------------------------------
module sic_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/sic_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_front
// Three-stage front end: differences, products, classification.
// ----------------------------------------------------------------------------
module sic_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [47:0]   tol,
	input  logic          push,
	output logic          full,
	input  sic_pkg::seg_t seg,
	output logic          mid_push,
	output sic_pkg::mid_t mid,
	input  logic          mid_full
);
	import sic_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3;

	logic signed [23:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic signed [24:0] dax_s1, day_s1, dbx_s1, dby_s1, wx_s1, wy_s1, gx_s1, gy_s1;
	logic signed [24:0] dax_s2, day_s2;
	logic signed [25:0] sx_s1, sy_s1, sx_s2, sy_s2;
	logic signed [49:0] pc1_s2, pc2_s2, pw1_s2, pw2_s2, pt1_s2, pt2_s2;
	logic signed [49:0] pb1_s2, pb2_s2, pe1_s2, pe2_s2, pl1_s2, pl2_s2;
	mid_t mid_s3;
	mid_t nx;

	function automatic logic is_small(input logic signed [50:0] v, input logic [47:0] t);
		logic [50:0] m;
		m = (v < 0) ? 51'(-v) : 51'(v);
		return (v == '0) || (m < {3'b000, t});
	endfunction

	assign adv      = !(v_s3 && mid_full);
	assign full     = !adv;
	assign mid_push = v_s3 && !mid_full;
	assign mid      = mid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1  <= seg.a_start_x;
			ay_s1  <= seg.a_start_y;
			dax_s1 <= 25'(seg.a_end_x) - 25'(seg.a_start_x);
			day_s1 <= 25'(seg.a_end_y) - 25'(seg.a_start_y);
			dbx_s1 <= 25'(seg.b_end_x) - 25'(seg.b_start_x);
			dby_s1 <= 25'(seg.b_end_y) - 25'(seg.b_start_y);
			wx_s1  <= 25'(seg.b_start_x) - 25'(seg.a_start_x);
			wy_s1  <= 25'(seg.b_start_y) - 25'(seg.a_start_y);
			gx_s1  <= 25'(seg.b_end_x) - 25'(seg.a_start_x);
			gy_s1  <= 25'(seg.b_end_y) - 25'(seg.a_start_y);
			sx_s1  <= 26'(seg.a_start_x) + 26'(seg.a_end_x) + 26'(seg.b_start_x)
				+ 26'(seg.b_end_x);
			sy_s1  <= 26'(seg.a_start_y) + 26'(seg.a_end_y) + 26'(seg.b_start_y)
				+ 26'(seg.b_end_y);

			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			dax_s2 <= dax_s1;
			day_s2 <= day_s1;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			pc1_s2 <= dax_s1 * dby_s1;
			pc2_s2 <= day_s1 * dbx_s1;
			pw1_s2 <= wx_s1 * day_s1;
			pw2_s2 <= wy_s1 * dax_s1;
			pt1_s2 <= wx_s1 * dby_s1;
			pt2_s2 <= wy_s1 * dbx_s1;
			pb1_s2 <= wx_s1 * dax_s1;
			pb2_s2 <= wy_s1 * day_s1;
			pe1_s2 <= gx_s1 * dax_s1;
			pe2_s2 <= gy_s1 * day_s1;
			pl1_s2 <= dax_s1 * dax_s1;
			pl2_s2 <= day_s1 * day_s1;

			mid_s3 <= nx;
		end
	end

	always_comb begin
		logic signed [50:0] c, nu, nt, pb, pe, len, lo, hi, clo, chi;
		c   = 51'(pc1_s2) - 51'(pc2_s2);
		nu  = 51'(pw1_s2) - 51'(pw2_s2);
		nt  = 51'(pt1_s2) - 51'(pt2_s2);
		pb  = 51'(pb1_s2) + 51'(pb2_s2);
		pe  = 51'(pe1_s2) + 51'(pe2_s2);
		len = 51'(pl1_s2) + 51'(pl2_s2);
		lo  = (pb < pe) ? pb : pe;
		hi  = (pb < pe) ? pe : pb;
		clo = (lo > 0) ? lo : '0;
		chi = (hi < len) ? hi : len;

		nx.base_x = ax_s2;
		nx.base_y = ay_s2;
		nx.dx     = 26'(dax_s2);
		nx.dy     = 26'(day_s2);
		nx.num    = '0;
		nx.den    = 50'd1;
		nx.rel    = REL_OVERLAP;

		if (is_small(c, tol)) begin
			if (is_small(nu, tol)) begin
				if (len == '0) begin
					nx.rel = REL_OVERLAP;
				end else begin
					nx.den = {len[48:0], 1'b0};
					if (hi < 0) begin
						nx.rel = REL_APART;
						nx.num = hi;
					end else if (lo > len) begin
						nx.rel = REL_APART;
						nx.num = lo + len;
					end else begin
						nx.rel = REL_OVERLAP;
						nx.num = clo + chi;
					end
				end
			end else begin
				nx.rel    = REL_PARALLEL;
				nx.base_x = '0;
				nx.base_y = '0;
				nx.dx     = sx_s2;
				nx.dy     = sy_s2;
				nx.num    = 51'sd1;
				nx.den    = 50'd4;
			end
		end else begin
			if (c < 0) begin
				c  = -c;
				nt = -nt;
				nu = -nu;
			end
			nx.rel = (nt >= 0 && nt <= c && nu >= 0 && nu <= c) ? REL_CROSS_ON
				: REL_CROSS_OFF;
			nx.num = nt;
			nx.den = c[49:0];
		end
	end

endmodule

// ===== rtl/sic_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sic_back
// Back end: magnitude products, pipelined restoring divide, round, saturate.
// ----------------------------------------------------------------------------
module sic_back (
	input  logic          clk,
	input  logic          arst_n,
	input  sic_pkg::mid_t mid,
	input  logic          mid_empty,
	output logic          mid_pop,
	output logic          res_push,
	output sic_pkg::res_t res,
	input  logic          res_full
);
	import sic_pkg::*;

	localparam logic [41:0] QCAP = 42'd1 << QBITS;

	logic adv;
	logic v_s1, v_s2;
	logic vld_q [QBITS+1];

	logic [2:0]         rel_s1, rel_s2;
	logic signed [23:0] bx_s1, by_s1, bx_s2, by_s2;
	logic [49:0]        den_s1, den_s2;
	logic               ngx_s1, ngy_s1, ngx_s2, ngy_s2;
	logic [25:0]        udx_s1, udy_s1;
	logic [24:0]        unh_s1;
	logic [50:0]        plx_s1, ply_s1;
	logic [74:0]        px_s2, py_s2;

	logic [25:0] udx, udy;
	logic [49:0] un;
	logic [50:0] phx, phy;

	logic [2:0]         rel_q [QBITS+1];
	logic signed [23:0] bx_q  [QBITS+1];
	logic signed [23:0] by_q  [QBITS+1];
	logic [49:0]        den_q [QBITS+1];
	logic               ngx_q [QBITS+1];
	logic               ngy_q [QBITS+1];
	logic               stx_q [QBITS+1];
	logic               sty_q [QBITS+1];
	logic [49:0]        rx_q  [QBITS+1];
	logic [49:0]        ry_q  [QBITS+1];
	logic [QBITS-1:0]   lx_q  [QBITS+1];
	logic [QBITS-1:0]   ly_q  [QBITS+1];
	logic [QBITS-1:0]   qx_q  [QBITS+1];
	logic [QBITS-1:0]   qy_q  [QBITS+1];

	logic [49:0]      rx_nx [QBITS];
	logic [49:0]      ry_nx [QBITS];
	logic [QBITS-1:0] qx_nx [QBITS];
	logic [QBITS-1:0] qy_nx [QBITS];

	function automatic logic signed [23:0] finish(input logic [QBITS-1:0] q,
		input logic [49:0] r, input logic [49:0] d, input logic st,
		input logic ng, input logic signed [23:0] base);
		logic [41:0]        qm;
		logic signed [43:0] qs;
		logic signed [43:0] sum;
		qm = st ? QCAP : (42'(q) + 42'(({r, 1'b0} >= {1'b0, d})));
		qs = ng ? -44'(qm) : 44'(qm);
		sum = 44'(base) + qs;
		if (sum > 44'sd8388607) begin
			return 24'sh7fffff;
		end else if (sum < -44'sd8388608) begin
			return 24'sh800000;
		end
		return sum[23:0];
	endfunction

	assign adv      = !(vld_q[QBITS] && res_full);
	assign mid_pop  = adv && !mid_empty;
	assign res_push = vld_q[QBITS] && !res_full;

	assign udx = (mid.dx < 0) ? 26'(-mid.dx) : 26'(mid.dx);
	assign udy = (mid.dy < 0) ? 26'(-mid.dy) : 26'(mid.dy);
	assign un  = (mid.num < 0) ? 50'(-mid.num) : 50'(mid.num);
	assign phx = udx_s1 * unh_s1;
	assign phy = udy_s1 * unh_s1;

	always_comb begin
		for (int k = 0; k < QBITS; k++) begin
			logic [50:0] tx, ty;
			logic        gx, gy;
			tx = {rx_q[k], lx_q[k][QBITS-1-k]};
			ty = {ry_q[k], ly_q[k][QBITS-1-k]};
			gx = (tx >= {1'b0, den_q[k]});
			gy = (ty >= {1'b0, den_q[k]});
			rx_nx[k] = gx ? 50'(tx - {1'b0, den_q[k]}) : tx[49:0];
			ry_nx[k] = gy ? 50'(ty - {1'b0, den_q[k]}) : ty[49:0];
			qx_nx[k] = {qx_q[k][QBITS-2:0], gx};
			qy_nx[k] = {qy_q[k][QBITS-2:0], gy};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k <= QBITS; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s1     <= !mid_empty;
			v_s2     <= v_s1;
			vld_q[0] <= v_s2;
			for (int k = 0; k < QBITS; k++) begin
				vld_q[k+1] <= vld_q[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rel_s1 <= mid.rel;
			bx_s1  <= mid.base_x;
			by_s1  <= mid.base_y;
			den_s1 <= mid.den;
			ngx_s1 <= (mid.dx < 0) ^ (mid.num < 0);
			ngy_s1 <= (mid.dy < 0) ^ (mid.num < 0);
			udx_s1 <= udx;
			udy_s1 <= udy;
			unh_s1 <= un[49:25];
			plx_s1 <= udx * un[24:0];
			ply_s1 <= udy * un[24:0];

			rel_s2 <= rel_s1;
			bx_s2  <= bx_s1;
			by_s2  <= by_s1;
			den_s2 <= den_s1;
			ngx_s2 <= ngx_s1;
			ngy_s2 <= ngy_s1;
			px_s2  <= 75'(plx_s1) + (75'(phx) << 25);
			py_s2  <= 75'(ply_s1) + (75'(phy) << 25);

			rel_q[0] <= rel_s2;
			bx_q[0]  <= bx_s2;
			by_q[0]  <= by_s2;
			den_q[0] <= den_s2;
			ngx_q[0] <= ngx_s2;
			ngy_q[0] <= ngy_s2;
			stx_q[0] <= (50'(px_s2[74:QBITS]) >= den_s2);
			sty_q[0] <= (50'(py_s2[74:QBITS]) >= den_s2);
			rx_q[0]  <= 50'(px_s2[74:QBITS]);
			ry_q[0]  <= 50'(py_s2[74:QBITS]);
			lx_q[0]  <= px_s2[QBITS-1:0];
			ly_q[0]  <= py_s2[QBITS-1:0];
			qx_q[0]  <= '0;
			qy_q[0]  <= '0;

			for (int k = 0; k < QBITS; k++) begin
				rel_q[k+1] <= rel_q[k];
				bx_q[k+1]  <= bx_q[k];
				by_q[k+1]  <= by_q[k];
				den_q[k+1] <= den_q[k];
				ngx_q[k+1] <= ngx_q[k];
				ngy_q[k+1] <= ngy_q[k];
				stx_q[k+1] <= stx_q[k];
				sty_q[k+1] <= sty_q[k];
				lx_q[k+1]  <= lx_q[k];
				ly_q[k+1]  <= ly_q[k];
				rx_q[k+1]  <= rx_nx[k];
				ry_q[k+1]  <= ry_nx[k];
				qx_q[k+1]  <= qx_nx[k];
				qy_q[k+1]  <= qy_nx[k];
			end
		end
	end

	assign res.relation = rel_q[QBITS];
	assign res.point_x  = finish(qx_q[QBITS], rx_q[QBITS], den_q[QBITS], stx_q[QBITS],
		ngx_q[QBITS], bx_q[QBITS]);
	assign res.point_y  = finish(qy_q[QBITS], ry_q[QBITS], den_q[QBITS], sty_q[QBITS],
		ngy_q[QBITS], by_q[QBITS]);

endmodule

// ===== rtl/segment_intersection_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_classifier_core
// Classifies how two 2D segments meet and returns a representative point.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// segments  in         push / full               seg   (seg_t)
// results   out        pop / empty               res   (res_t)
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item per cycle sustained while the result queue does not fill. Path: three
// front stages, the middle queue, two product stages, one saturation check and a
// 41-stage restoring divider (one quotient bit per stage), then the result queue.
// Reset clears control only. A full result queue stalls the back end; the
// front end stalls only when the middle queue is also full.
// ----------------------------------------------------------------------------
module segment_intersection_classifier_core #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	input  logic          push,
	output logic          full,
	input  sic_pkg::seg_t seg,
	output logic          empty,
	input  logic          pop,
	output sic_pkg::res_t res
);
	import sic_pkg::*;

	logic [47:0]      tol_q;
	logic             mq_push, mq_full, mq_pop, mq_empty;
	mid_t             mq_wdata, mq_rdata;
	logic [MID_W-1:0] mq_rbits;
	logic             rq_push, rq_full;
	res_t             rq_wdata;
	logic [RES_W-1:0] rq_rbits;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_TOL) ? {16'h0000, tol_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && paddr[3] == REG_TOL) begin
			tol_q <= pwdata[47:0];
		end
	end

	sic_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tol      (tol_q),
		.push     (push),
		.full     (full),
		.seg      (seg),
		.mid_push (mq_push),
		.mid      (mq_wdata),
		.mid_full (mq_full)
	);

	sic_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_midq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.wdata  (mq_wdata),
		.full   (mq_full),
		.pop    (mq_pop),
		.rdata  (mq_rbits),
		.empty  (mq_empty)
	);

	assign mq_rdata = mid_t'(mq_rbits);

	sic_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid       (mq_rdata),
		.mid_empty (mq_empty),
		.mid_pop   (mq_pop),
		.res_push  (rq_push),
		.res       (rq_wdata),
		.res_full  (rq_full)
	);

	sic_fifo #(.WIDTH(RES_W), .DEPTH(OUT_DEPTH)) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rbits),
		.empty  (empty)
	);

	assign res = res_t'(rq_rbits);

endmodule
